[src/lru_key_value_cache_assert.svh]
// assertion macros for the lru key/value cache
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

`define LKV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define LKV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LKV_ASSERT(label, ante, cons, msg)

`define LKV_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[src/lkv_pkg.sv]
// shared types and constants for the lru key/value cache
package lkv_pkg;

    localparam int CAP_BITS  = 5;
    localparam int APB_DATA  = 32;
    localparam int APB_ADDR  = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] RC_INSERTED    = 3'd0;
    localparam logic [2:0] RC_UPDATED     = 3'd1;
    localparam logic [2:0] RC_GET_HIT     = 3'd2;
    localparam logic [2:0] RC_GET_MISS    = 3'd3;
    localparam logic [2:0] RC_REMOVED     = 3'd4;
    localparam logic [2:0] RC_REMOVE_MISS = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PREV,
        CELL_NEXT,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

endpackage

[src/lkv_cell.sv]
// one entry of the recency-ordered chain: key, data, valid and key match
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  logic [KEY_BITS-1:0]  cmp_key,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic [DATA_BITS-1:0] new_data,
    input  logic                 prev_valid,
    input  logic [KEY_BITS-1:0]  prev_key,
    input  logic [DATA_BITS-1:0] prev_data,
    input  logic                 next_valid,
    input  logic [KEY_BITS-1:0]  next_key,
    input  logic [DATA_BITS-1:0] next_data,
    output logic                 valid,
    output logic [KEY_BITS-1:0]  key,
    output logic [DATA_BITS-1:0] data,
    output logic                 match
);

    logic                 valid_reg, valid_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic                 match_reg, match_next;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_PREV: begin
                valid_next = prev_valid;
                key_next   = prev_key;
                data_next  = prev_data;
            end
            CELL_NEXT: begin
                valid_next = next_valid;
                key_next   = next_key;
                data_next  = next_data;
            end
            CELL_LOAD: begin
                valid_next = 1'b1;
                key_next   = new_key;
                data_next  = new_data;
            end
            default: begin
            end
        endcase
        match_next = ctrl.cmp_en ? (valid_reg && (key_reg == cmp_key)) : match_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign data  = data_reg;
    assign match = match_reg;

endmodule

[src/lru_key_value_cache.sv]
// top level of the lru key/value cache: cell chain, sequencer, apb register
//
//  channel | ports             | handshake      | word
//  --------+-------------------+----------------+---------------------------------
//  input   | s_op/s_key/s_value| s_valid/s_ready| one operation
//  result  | m_result_code ... | m_valid/m_ready| code, read value, evicted key
//  config  | psel ... prdata   | apb, pready=1  | capacity at address 0
//
// one word at a time: the accept edge registers a key match in every cell;
// the update step then shifts the recency chain and loads the result register.
// the chain is kept in recency order, most recent in cell 0
// reset clears all valid bits at once, no clearing pass
// a full result register holds the update step until m_ready
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_ADDR-1:0]  paddr,
    input  logic [APB_DATA-1:0]  pwdata,
    output logic [APB_DATA-1:0]  prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic [KEY_BITS-1:0]  s_key,
    input  logic [DATA_BITS-1:0] s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_result_code,
    output logic [DATA_BITS-1:0] m_read_value,
    output logic                 m_evicted_valid,
    output logic [KEY_BITS-1:0]  m_evicted_key
);

`include "lru_key_value_cache_assert.svh"

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CAP_BITS-1:0]  capacity_reg, capacity_next;
    logic [CW-1:0]        occ_reg, occ_next;
    logic [1:0]           op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] value_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_code_reg, m_code_next;
    logic [DATA_BITS-1:0] m_rd_reg, m_rd_next;
    logic                 m_ev_reg, m_ev_next;
    logic [KEY_BITS-1:0]  m_evk_reg, m_evk_next;

    cell_ctrl_t           ctrl [MAX_ENTRIES];
    logic [KEY_BITS-1:0]  cell_key  [MAX_ENTRIES];
    logic [DATA_BITS-1:0] cell_data [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_vec, match_vec, valid_dn, last_vec;

    logic                 accept, out_free, do_update, cfg_wr;
    logic                 is_put, is_remove, hit, evict;
    logic [IW-1:0]        s_idx;
    logic [CW-1:0]        eff_cap;
    logic [DATA_BITS-1:0] hit_data, new_data;
    logic [KEY_BITS-1:0]  last_key;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[APB_ADDR-1] == 1'b0) ?
                    APB_DATA'(capacity_reg) : '0;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_wr && (paddr[APB_ADDR-1] == 1'b0)) begin
            capacity_next = pwdata[CAP_BITS-1:0];
        end
    end

    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = CW'(1);
        end else if (32'(capacity_reg) > 32'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(capacity_reg);
        end
    end

    // handshake
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign do_update = (state_reg == ST_UPDATE) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // cell chain
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic                 pv, nv;
            logic [KEY_BITS-1:0]  pk, nk;
            logic [DATA_BITS-1:0] pd, nd;

            if (g == 0) begin : g_first
                assign pv = 1'b0;
                assign pk = '0;
                assign pd = '0;
            end else begin : g_mid_prev
                assign pv = valid_vec[g-1];
                assign pk = cell_key[g-1];
                assign pd = cell_data[g-1];
            end

            if (g == MAX_ENTRIES - 1) begin : g_last
                assign nv = 1'b0;
                assign nk = '0;
                assign nd = '0;
            end else begin : g_mid_next
                assign nv = valid_vec[g+1];
                assign nk = cell_key[g+1];
                assign nd = cell_data[g+1];
            end

            lkv_cell #(
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl[g]),
                .cmp_key    (s_key),
                .new_key    (key_reg),
                .new_data   (new_data),
                .prev_valid (pv),
                .prev_key   (pk),
                .prev_data  (pd),
                .next_valid (nv),
                .next_key   (nk),
                .next_data  (nd),
                .valid      (valid_vec[g]),
                .key        (cell_key[g]),
                .data       (cell_data[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    assign valid_dn = valid_vec << 1;
    assign last_vec = valid_vec & ~(valid_vec >> 1);

    // hit position, hit data and least recent key
    always_comb begin
        s_idx    = '0;
        hit_data = '0;
        last_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_vec[i]) begin
                s_idx    = s_idx | IW'(i);
                hit_data = hit_data | cell_data[i];
            end
            if (last_vec[i]) begin
                last_key = last_key | cell_key[i];
            end
        end
    end

    always_comb begin
        is_put    = 1'b0;
        is_remove = 1'b0;
        case (op_reg)
            OP_PUT:    is_put = 1'b1;
            OP_REMOVE: is_remove = 1'b1;
            default: begin
            end
        endcase
    end

    assign hit      = |match_vec;
    assign evict    = is_put && !hit && (occ_reg >= eff_cap);
    assign new_data = is_put ? value_reg : hit_data;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].cmp_en = accept;
            ctrl[i].op     = CELL_HOLD;
            if (do_update) begin
                if (is_remove) begin
                    if (hit && (IW'(i) >= s_idx)) begin
                        ctrl[i].op = CELL_NEXT;
                    end
                end else if (hit) begin
                    if (i == 0) begin
                        ctrl[i].op = CELL_LOAD;
                    end else if (IW'(i) <= s_idx) begin
                        ctrl[i].op = CELL_PREV;
                    end
                end else if (is_put) begin
                    if (i == 0) begin
                        ctrl[i].op = CELL_LOAD;
                    end else if (evict ? valid_vec[i] : valid_dn[i]) begin
                        ctrl[i].op = CELL_PREV;
                    end
                end
            end
        end
    end

    // occupancy and result register
    always_comb begin
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_rd_next    = m_rd_reg;
        m_ev_next    = m_ev_reg;
        m_evk_next   = m_evk_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (do_update) begin
            m_valid_next = 1'b1;
            m_rd_next    = '0;
            m_ev_next    = evict;
            m_evk_next   = evict ? last_key : '0;
            if (is_put) begin
                m_code_next = hit ? RC_UPDATED : RC_INSERTED;
                if (!hit && !evict) begin
                    occ_next = occ_reg + CW'(1);
                end
            end else if (is_remove) begin
                m_code_next = hit ? RC_REMOVED : RC_REMOVE_MISS;
                if (hit) begin
                    occ_next = occ_reg - CW'(1);
                end
            end else begin
                m_code_next = hit ? RC_GET_HIT : RC_GET_MISS;
                m_rd_next   = hit ? hit_data : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            occ_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            capacity_reg <= capacity_next;
            occ_reg      <= occ_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_op;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
        m_code_reg <= m_code_next;
        m_rd_reg   <= m_rd_next;
        m_ev_reg   <= m_ev_next;
        m_evk_reg  <= m_evk_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_code   = m_code_reg;
    assign m_read_value    = m_rd_reg;
    assign m_evicted_valid = m_ev_reg;
    assign m_evicted_key   = m_evk_reg;

    `LKV_ASSERT(a_match_unique, 1'b1, $onehot0(match_vec), "key matched in two cells")
    `LKV_ASSERT(a_chain_packed, 1'b1, ((valid_vec & (valid_vec + 1'b1)) == '0), "gap in chain")
    `LKV_ASSERT(a_occ_count, 1'b1, (32'(occ_reg) == $countones(valid_vec)), "occupancy drift")
    `LKV_ASSERT_NXT(a_accept_update, accept, (state_reg == ST_UPDATE), "no update after accept")
    `LKV_ASSERT_NXT(a_update_result, do_update, m_valid, "update gave no result")

endmodule

[verif/lru_key_value_cache_checker.sv]
// checker for the lru key/value cache: watches both channels and the apb port, predicts and compares
`timescale 1ns / 100ps
module lru_key_value_cache_checker
    import lkv_pkg::*;
#(
    parameter int                  MAX_ENTRIES = 16,
    parameter int                  KEY_BITS    = 32,
    parameter int                  DATA_BITS   = 32,
    parameter logic [APB_ADDR-1:0] CAP_ADDR    = '0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_ADDR-1:0]  paddr,
    input  logic [APB_DATA-1:0]  pwdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic [KEY_BITS-1:0]  s_key,
    input  logic [DATA_BITS-1:0] s_value,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [2:0]           m_result_code,
    input  logic [DATA_BITS-1:0] m_read_value,
    input  logic                 m_evicted_valid,
    input  logic [KEY_BITS-1:0]  m_evicted_key,
    output int                   fail_count,
    output int                   pending_words
);

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } entry_t;

    typedef struct packed {
        logic [2:0]           code;
        logic [DATA_BITS-1:0] read_value;
        logic                 evicted;
        logic [KEY_BITS-1:0]  victim_key;
    } outcome_t;

    // index 0 is the most recently used entry
    entry_t             recency_list[$];
    outcome_t           awaited_outcomes[$];
    logic [CAP_BITS-1:0] capacity_reg;

    function automatic int find_entry(input logic [KEY_BITS-1:0] key);
        for (int i = 0; i < recency_list.size(); i++) begin
            if (recency_list[i].key == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic outcome_t apply_word(input logic [1:0] op,
                                            input logic [KEY_BITS-1:0] key,
                                            input logic [DATA_BITS-1:0] value);
        outcome_t res;
        entry_t   slot;
        int       idx;
        int       limit;
        res = '0;
        idx = find_entry(key);
        limit = (capacity_reg == 0) ? 1 :
                (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
        case (op)
            OP_PUT: begin
                if (idx >= 0) begin
                    recency_list.delete(idx);
                    res.code = RC_UPDATED;
                end else begin
                    // may evict just one even if capacity was lowered below occupancy
                    if (recency_list.size() >= limit && recency_list.size() > 0) begin
                        slot = recency_list.pop_back();
                        res.evicted = 1'b1;
                        res.victim_key = slot.key;
                    end
                    res.code = RC_INSERTED;
                end
                if (recency_list.size() < MAX_ENTRIES) begin
                    slot.key = key;
                    slot.data = value;
                    recency_list.push_front(slot);
                end
            end
            OP_REMOVE: begin
                if (idx >= 0) begin
                    recency_list.delete(idx);
                    res.code = RC_REMOVED;
                end else begin
                    res.code = RC_REMOVE_MISS;
                end
            end
            default: begin
                if (idx >= 0) begin
                    slot = recency_list[idx];
                    recency_list.delete(idx);
                    recency_list.push_front(slot);
                    res.read_value = slot.data;
                    res.code = RC_GET_HIT;
                end else begin
                    res.code = RC_GET_MISS;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            recency_list.delete();
            awaited_outcomes.delete();
            capacity_reg = CAP_RESET;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
                capacity_reg = pwdata[CAP_BITS-1:0];
            end
            if (s_valid && s_ready) begin
                awaited_outcomes.push_back(apply_word(s_op, s_key, s_value));
            end
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result word with none awaited: code %0d", m_result_code);
                    fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("result_code", want.code, m_result_code);
                    compare_field("read_value", want.read_value, m_read_value);
                    compare_field("evicted_valid", want.evicted, m_evicted_valid);
                    compare_field("victim_key", want.victim_key, m_evicted_key);
                end
            end
        end
        pending_words = awaited_outcomes.size();
    end

endmodule

[verif/lru_key_value_cache_tb.sv]
// testbench top for the lru key/value cache: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int                  MAX_ENTRIES  = 16;
    localparam int                  KEY_BITS     = 32;
    localparam int                  DATA_BITS    = 32;
    localparam logic [APB_ADDR-1:0] REG_CAPACITY = '0;
    localparam logic [1:0]          OP_GET_ALT   = 2'd3;
    localparam int                  HOLD_PHASE   = 2;
    localparam int                  STEADY_PHASE = 7;
    localparam int                  HOLD_CYCLES  = 120;
    localparam int                  PHASE_WORDS  = 64;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_ADDR-1:0]  paddr;
    logic [APB_DATA-1:0]  pwdata;
    logic [APB_DATA-1:0]  prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_op;
    logic [KEY_BITS-1:0]  s_key;
    logic [DATA_BITS-1:0] s_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_result_code;
    logic [DATA_BITS-1:0] m_read_value;
    logic                 m_evicted_valid;
    logic [KEY_BITS-1:0]  m_evicted_key;

    int                   fail_count;
    int                   pending_words;
    int                   phase_num;
    bit                   steady;
    bit                   hold_done;
    logic [KEY_BITS-1:0]  key_pool[$];

    lru_key_value_cache #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .DATA_BITS  (DATA_BITS)
    ) dut (.*);

    lru_key_value_cache_checker #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .DATA_BITS  (DATA_BITS),
        .CAP_ADDR   (REG_CAPACITY)
    ) u_checker (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("lru_key_value_cache_tb: done, errors");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (phase_num == HOLD_PHASE && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= (phase_num == STEADY_PHASE) ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                             input logic [DATA_BITS-1:0] value);
        while (!steady && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        s_valid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= ($urandom() & ~32'h1F) | APB_DATA'(cap);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [CAP_BITS-1:0]  cap_plan[10];
        logic [1:0]           op;
        logic [KEY_BITS-1:0]  key;
        int                   r;
        int                   pool_len;
        cap_plan = '{5'd31, 5'd2, 5'd16, 5'd3, 5'd1, 5'd0, 5'd8, 5'd16, 5'd4, 5'd12};
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_op      = OP_PUT;
        s_key     = '0;
        s_value   = '0;
        phase_num = 0;
        steady    = 1'b0;
        hold_done = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_word(OP_GET, '0, '0);
        send_word(OP_REMOVE, '1, '0);
        send_word(OP_PUT, '0, '0);
        send_word(OP_PUT, '1, '1);
        send_word(OP_GET, '1, '0);
        send_word(OP_GET_ALT, '0, '1);
        send_word(OP_PUT, '0, 32'h5A5A_A5A5);
        send_word(OP_GET, '0, '0);
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_REMOVE, '0, '0);
        // capacity zero acts as one
        write_capacity(5'd0);
        send_word(OP_PUT, 32'h1, 32'h11);
        send_word(OP_PUT, 32'h2, 32'h22);
        send_word(OP_GET, 32'h1, '0);
        send_word(OP_GET_ALT, 32'h2, '0);

        for (int p = 0; p < 10; p++) begin
            write_capacity(cap_plan[p]);
            phase_num = p + 1;
            steady = (phase_num == STEADY_PHASE);
            pool_len = (cap_plan[p] == 0) ? 1 :
                       (cap_plan[p] > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_plan[p]);
            pool_len += $urandom_range(1, 4);
            key_pool.delete();
            repeat (pool_len) key_pool.push_back($urandom());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(99);
                op = (r < 45) ? OP_PUT : (r < 78) ? OP_GET : (r < 92) ? OP_REMOVE : OP_GET_ALT;
                key = ($urandom_range(99) < 6) ? $urandom() :
                      key_pool[$urandom_range(key_pool.size() - 1)];
                send_word(op, key, $urandom());
            end
        end

        s_valid <= 1'b0;
        steady = 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("lru_key_value_cache_tb: done, clean");
        end else begin
            $display("lru_key_value_cache_tb: done, errors");
        end
        $finish;
    end

endmodule
